// File: design/trd_pkg.sv
// shared types and constants for the threshold and region dilation block
package trd_pkg;

  localparam int DEF_MAX_COLS = 2048;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_HALO     = 15;

  localparam int SAMPLE_W  = 16;
  localparam int ROW_W     = 10;
  localparam int COL_W     = 11;
  localparam int VALUE_W   = 32;
  localparam int THR_W     = 31;
  localparam int GROWS_W   = 11;
  localparam int GCOLS_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_DATA_W = 16;
  localparam int IN_USER_W = 1;
  localparam int OUT_DATA_W = 56;
  localparam int SUM_W     = 42;

  localparam int PIPE_STAGES = 7;
  localparam int FIFO_DEPTH  = 16;

  localparam logic [THR_W-1:0]   RST_THRESHOLD = 31'd2621440;
  localparam logic [31:0]        RST_SCALE     = 32'd16777216;
  localparam logic [31:0]        RST_OFFSET    = 32'd0;
  localparam logic [GROWS_W-1:0] RST_ROWS      = 11'd721;
  localparam logic [GCOLS_W-1:0] RST_COLS      = 12'd1440;

  localparam logic FUNC_SAMPLE = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_SCALE     = 3'd1,
    CFG_OFFSET    = 3'd2,
    CFG_GRID_ROWS = 3'd3,
    CFG_GRID_COLS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic seed;
    logic par;
  } cell_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    logic                      seed;
    logic                      region;
    logic                      last;
  } res_t;

endpackage

// File: design/trd_ram.sv
// generic single-write, single-read memory with registered read
module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/trd_scale.sv
// two-stage sample scaler: raw*scale rounded to q16.16 plus offset
module trd_scale (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [trd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [31:0]                 scale_i,
  input  logic signed [31:0]                 offset_i,
  output logic signed [trd_pkg::SUM_W-1:0]   sum_o
);
  import trd_pkg::*;

  logic signed [47:0]      prod_r;
  logic signed [48:0]      prod_rnd;
  logic signed [40:0]      prod_q16;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;

  always_comb begin
    prod_rnd = $signed({prod_r[47], prod_r}) + 49'sd128;
    // floor shift gives round half up
    prod_q16 = prod_rnd[48:8];
    sum_nxt  = $signed({prod_q16[40], prod_q16}) + $signed({{10{offset_i[31]}}, offset_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sample_i * scale_i;
      sum_r  <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

// File: design/trd_cell.sv
// one cell of the seed window chain: holds a seed bit with its row parity
module trd_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  logic           clear,
  input  trd_pkg::cell_t d_i,
  output trd_pkg::cell_t q_o
);
  import trd_pkg::*;

  cell_t cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cell_r.valid <= 1'b0;
    end else if (shift) begin
      cell_r <= d_i;
    end
  end

  assign q_o = cell_r;

endmodule

// File: design/threshold_region_dilate_top.sv
// top level of the threshold and square dilation block
//
// Input channel in_*: one request per grid sample in raster order (in_tuser = 0)
// or a flush tick (in_tuser = 1). Result channel out_*: one cell per request once
// its look-ahead of 15*cols+15 samples has arrived, or at once after the frame is
// complete; out_tlast marks the final cell. Configuration writes go through cfg_*
// and are taken in every cycle; a grid size write abandons the frame in progress.
// Throughput is one request per cycle while the queue has room and no internal
// stepping runs. A result passes the step pipeline after the request that releases
// it and sits in a 16-entry output queue. When the receiver stalls, the queue fills
// and in_tready drops once 9 results wait. Grids of fewer than 16 rows: after the final
// sample the block steps internally until the look-ahead count is reached, in_tready low.
// Reset clears positions, the window chain and the queue; the sample delay memory
// and the column count memory are not cleared (the first row of every frame
// ignores the column counts).
module threshold_region_dilate_top #(
  parameter int MAX_COLS = trd_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = trd_pkg::DEF_MAX_ROWS,
  parameter int HALO     = trd_pkg::DEF_HALO
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [trd_pkg::IN_DATA_W-1:0]    in_tdata,   // sample
  input  logic [trd_pkg::IN_USER_W-1:0]    in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [trd_pkg::OUT_DATA_W-1:0]   out_tdata,  // row, col, value_q, is_seed, in_region
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [trd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trd_pkg::CFG_DW-1:0]       cfg_data
);
  import trd_pkg::*;

  localparam int RBITS     = $clog2(MAX_ROWS);
  localparam int CBITS     = $clog2(MAX_COLS);
  localparam int DLY_DEPTH = (HALO + 1) * MAX_COLS;
  localparam int DAW       = $clog2(DLY_DEPTH);
  localparam int WIN       = 2 * HALO;
  localparam int NW        = $clog2(WIN);
  localparam int FPW       = $clog2(FIFO_DEPTH);
  localparam int FCW       = $clog2(FIFO_DEPTH + 1);
  localparam logic [13:0] MAX_ROWS_W = 14'(MAX_ROWS);
  localparam logic [13:0] MAX_COLS_W = 14'(MAX_COLS);
  localparam logic [13:0] MIN_COLS_W = 14'(2 * HALO + 1);
  localparam logic [NW-1:0] CNT_INIT = NW'(WIN - 1);

  typedef struct packed {
    logic             valid;
    logic             shift;
    logic             samp;
    logic             emit;
    logic             qa;
    logic             qfirst;
    logic             last;
    logic             par;
    logic             seed;
    logic             region;
    logic [RBITS-1:0] row;
    logic [CBITS-1:0] col;
    logic [CBITS-1:0] qcol;
    logic [DAW-1:0]   wptr;
    logic [DAW-1:0]   rptr;
  } ctrl_t;

  // configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [31:0]        scale_r;
  logic [31:0]        offset_r;
  logic [GROWS_W-1:0] grid_rows_r;
  logic [GCOLS_W-1:0] grid_cols_r;
  logic               cfg_restart;

  // position state
  logic [RBITS-1:0] in_row_r, in_row_nxt;
  logic [CBITS-1:0] in_col_r, in_col_nxt;
  logic [RBITS-1:0] out_row_r, out_row_nxt;
  logic [CBITS-1:0] out_col_r, out_col_nxt;
  logic [CBITS-1:0] qcol_r, qcol_nxt;
  logic             qfirst_r, qfirst_nxt;
  logic             full_r, full_nxt;
  logic             pend_r, pend_nxt;
  logic [DAW-1:0]   p_r, p_nxt;
  logic [DAW-1:0]   wptr_r, wptr_nxt;
  logic [DAW-1:0]   rptr_r, rptr_nxt;

  logic [13:0]      rows_ext, cols_ext;
  logic [RBITS-1:0] rows_m1;
  logic [CBITS-1:0] cols_m1;
  logic [DAW-1:0]   lag;

  logic  en, accept, go, samp, shift, at_lag, emit, qa, frame_done, out_last, last_emit;
  ctrl_t ctrl0;
  ctrl_t st4_in;
  ctrl_t pipe_r [PIPE_STAGES];
  logic signed [SAMPLE_W-1:0] raw_r;
  logic signed [SAMPLE_W-1:0] raw5_r;
  logic [SAMPLE_W-1:0]        raw_d2_r, raw_d3_r;

  logic signed [SUM_W-1:0] sum_in, sum_out;
  logic                    seed3;
  cell_t                   chain [WIN];
  cell_t                   cell_in;
  logic                    chain_shift;
  logic                    h_any, h;

  logic [SAMPLE_W:0] dly_rdata;
  logic [NW-1:0]     cnt_rdata, cnt_eff, cnt_nxt;
  logic              region4;

  logic signed [VALUE_W-1:0] value_sat;
  res_t                      fifo_r [FIFO_DEPTH];
  res_t                      push_item;
  logic [FPW-1:0]            wp_r, rp_r;
  logic [FCW-1:0]            fifo_cnt_r;
  logic                      push, pop;

  // configuration port
  assign cfg_ready   = 1'b1;
  assign cfg_restart = cfg_valid &&
                       (cfg_idx_t'(cfg_index) == CFG_GRID_ROWS ||
                        cfg_idx_t'(cfg_index) == CFG_GRID_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= RST_THRESHOLD;
      scale_r     <= RST_SCALE;
      offset_r    <= RST_OFFSET;
      grid_rows_r <= RST_ROWS;
      grid_cols_r <= RST_COLS;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thr_r       <= cfg_data[THR_W-1:0];
        CFG_SCALE:     scale_r     <= cfg_data;
        CFG_OFFSET:    offset_r    <= cfg_data;
        CFG_GRID_ROWS: grid_rows_r <= cfg_data[GROWS_W-1:0];
        CFG_GRID_COLS: grid_cols_r <= cfg_data[GCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid size and look-ahead distance
  always_comb begin
    rows_ext = {3'b0, grid_rows_r};
    if (rows_ext == 14'd0) rows_ext = 14'd1;
    if (rows_ext > MAX_ROWS_W) rows_ext = MAX_ROWS_W;
    cols_ext = {2'b0, grid_cols_r};
    if (cols_ext < MIN_COLS_W) cols_ext = MIN_COLS_W;
    if (cols_ext > MAX_COLS_W) cols_ext = MAX_COLS_W;
    rows_m1 = RBITS'(rows_ext - 14'd1);
    cols_m1 = CBITS'(cols_ext - 14'd1);
    lag     = DAW'(cols_ext) * DAW'(HALO) + DAW'(HALO);
  end

  // step decision
  assign en        = fifo_cnt_r <= FCW'(FIFO_DEPTH - PIPE_STAGES - 1);
  assign in_tready = en && !pend_r;
  assign accept    = in_tvalid && in_tready;
  assign go        = accept || (en && pend_r);
  assign samp      = accept && (in_tuser[0] == FUNC_SAMPLE) && !full_r;
  assign shift     = samp || (go && full_r);
  assign at_lag    = p_r == lag;
  assign emit      = shift && at_lag;
  assign qa        = shift && (p_r >= DAW'(HALO));
  assign frame_done = samp && (in_col_r == cols_m1) && (in_row_r == rows_m1);
  assign out_last  = (out_row_r == rows_m1) && (out_col_r == cols_m1);
  assign last_emit = emit && out_last;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    qcol_nxt    = qcol_r;
    qfirst_nxt  = qfirst_r;
    full_nxt    = full_r;
    pend_nxt    = pend_r;
    p_nxt       = p_r;
    wptr_nxt    = wptr_r;
    rptr_nxt    = rptr_r;
    if (samp) begin
      wptr_nxt = (wptr_r == DAW'(DLY_DEPTH - 1)) ? '0 : wptr_r + DAW'(1);
      if (in_col_r == cols_m1) begin
        in_col_nxt = '0;
        in_row_nxt = (in_row_r == rows_m1) ? '0 : in_row_r + RBITS'(1);
      end else begin
        in_col_nxt = in_col_r + CBITS'(1);
      end
    end
    if (shift && !at_lag) p_nxt = p_r + DAW'(1);
    if (qa) begin
      if (qcol_r == cols_m1) begin
        qcol_nxt   = '0;
        qfirst_nxt = 1'b0;
      end else begin
        qcol_nxt = qcol_r + CBITS'(1);
      end
    end
    if (emit) begin
      pend_nxt = 1'b0;
      rptr_nxt = (rptr_r == DAW'(DLY_DEPTH - 1)) ? '0 : rptr_r + DAW'(1);
      if (out_col_r == cols_m1) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + RBITS'(1);
      end else begin
        out_col_nxt = out_col_r + CBITS'(1);
      end
    end
    if (frame_done) begin
      full_nxt = 1'b1;
      // small grid: the frame ends before the look-ahead is reached
      if (!at_lag) pend_nxt = 1'b1;
    end
    if (last_emit || cfg_restart) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      qcol_nxt    = '0;
      qfirst_nxt  = 1'b1;
      full_nxt    = 1'b0;
      pend_nxt    = 1'b0;
      p_nxt       = '0;
      wptr_nxt    = '0;
      rptr_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      qcol_r    <= '0;
      qfirst_r  <= 1'b1;
      full_r    <= 1'b0;
      pend_r    <= 1'b0;
      p_r       <= '0;
      wptr_r    <= '0;
      rptr_r    <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      qcol_r    <= qcol_nxt;
      qfirst_r  <= qfirst_nxt;
      full_r    <= full_nxt;
      pend_r    <= pend_nxt;
      p_r       <= p_nxt;
      wptr_r    <= wptr_nxt;
      rptr_r    <= rptr_nxt;
    end
  end

  always_comb begin
    ctrl0        = '0;
    ctrl0.valid  = go;
    ctrl0.shift  = shift;
    ctrl0.samp   = samp;
    ctrl0.emit   = emit;
    ctrl0.qa     = qa;
    ctrl0.qfirst = qfirst_r;
    ctrl0.last   = out_last;
    ctrl0.par    = in_row_r[0];
    ctrl0.row    = out_row_r;
    ctrl0.col    = out_col_r;
    ctrl0.qcol   = qcol_r;
    ctrl0.wptr   = wptr_r;
    ctrl0.rptr   = rptr_r;
  end

  // stage 4 picks up the delayed seed and the window result
  always_comb begin
    st4_in        = pipe_r[3];
    st4_in.seed   = dly_rdata[SAMPLE_W];
    st4_in.region = region4;
  end

  // step pipeline, all stages advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        pipe_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      pipe_r[0] <= ctrl0;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        pipe_r[i] <= (i == 4) ? st4_in : pipe_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r  <= $signed(in_tdata[SAMPLE_W-1:0]);
      raw5_r <= $signed(dly_rdata[SAMPLE_W-1:0]);
    end
  end

  // raw value enters the delay memory three stages after accept
  always_ff @(posedge clk) begin
    if (en) begin
      raw_d2_r <= raw_r;
      raw_d3_r <= raw_d2_r;
    end
  end

  // seed test on arrival
  trd_scale u_scale_in (
    .clk      (clk),
    .en       (en),
    .sample_i (raw_r),
    .scale_i  ($signed(scale_r)),
    .offset_i ($signed(offset_r)),
    .sum_o    (sum_in)
  );

  assign seed3 = (sum_in > $signed({11'b0, thr_r})) ||
                 (sum_in < -$signed({11'b0, thr_r}));

  // raw sample and seed delayed by the look-ahead
  trd_ram #(
    .WIDTH (SAMPLE_W + 1),
    .DEPTH (DLY_DEPTH)
  ) u_dly_ram (
    .clk   (clk),
    .we    (en && pipe_r[2].valid && pipe_r[2].samp),
    .waddr (pipe_r[2].wptr),
    .wdata ({seed3, raw_d3_r}),
    .re    (en),
    .raddr (pipe_r[2].rptr),
    .rdata (dly_rdata)
  );

  // row of window cells, cell 0 holds the newest position
  assign chain_shift   = en && pipe_r[2].valid && pipe_r[2].shift;
  assign cell_in.valid = pipe_r[2].samp;
  assign cell_in.seed  = seed3;
  assign cell_in.par   = pipe_r[2].par;

  for (genvar g = 0; g < WIN; g++) begin : g_chain
    trd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (chain_shift),
      .clear (cfg_restart),
      .d_i   ((g == 0) ? cell_in : chain[(g == 0) ? 0 : g - 1]),
      .q_o   (chain[g])
    );
  end

  // horizontal window of the cell HALO places back, cut at its row ends
  always_comb begin
    h_any = 1'b0;
    for (int i = 0; i < WIN; i++) begin
      h_any = h_any | (chain[i].valid & chain[i].seed & (chain[i].par == chain[HALO].par));
    end
    h = h_any & chain[HALO].valid;
  end

  // per column: rows left in which a horizontal hit still reaches
  trd_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_COLS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (en && pipe_r[3].valid && pipe_r[3].qa),
    .waddr (pipe_r[3].qcol),
    .wdata (cnt_nxt),
    .re    (en),
    .raddr (pipe_r[2].qcol),
    .rdata (cnt_rdata)
  );

  always_comb begin
    cnt_eff = pipe_r[3].qfirst ? '0 : cnt_rdata;
    region4 = h || (cnt_eff != '0);
    if (h) begin
      cnt_nxt = CNT_INIT;
    end else if (cnt_eff != '0) begin
      cnt_nxt = cnt_eff - NW'(1);
    end else begin
      cnt_nxt = '0;
    end
  end

  // output value with the scale in force at emission
  trd_scale u_scale_out (
    .clk      (clk),
    .en       (en),
    .sample_i (raw5_r),
    .scale_i  ($signed(scale_r)),
    .offset_i ($signed(offset_r)),
    .sum_o    (sum_out)
  );

  always_comb begin
    if (sum_out[SUM_W-1:VALUE_W-1] == {(SUM_W-VALUE_W+1){sum_out[SUM_W-1]}}) begin
      value_sat = sum_out[VALUE_W-1:0];
    end else if (sum_out[SUM_W-1]) begin
      value_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      value_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    push_item.row    = ROW_W'(pipe_r[6].row);
    push_item.col    = COL_W'(pipe_r[6].col);
    push_item.value  = value_sat;
    push_item.seed   = pipe_r[6].seed;
    push_item.region = pipe_r[6].region;
    push_item.last   = pipe_r[6].last;
  end

  // output queue
  assign push = en && pipe_r[6].valid && pipe_r[6].emit;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FPW'(1);
      if (pop)  rp_r <= rp_r + FPW'(1);
      fifo_cnt_r <= fifo_cnt_r + FCW'(push) - FCW'(pop);
    end
  end

  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = {1'b0, fifo_r[rp_r].region, fifo_r[rp_r].seed, fifo_r[rp_r].value,
                       fifo_r[rp_r].col, fifo_r[rp_r].row};
  assign out_tlast  = fifo_r[rp_r].last;

  a_pend_full: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> full_r)
    else $error("internal stepping without a complete frame");

  a_pend_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_tready)
    else $error("request taken during internal stepping");

  a_emit_window: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[0].valid && pipe_r[0].emit |-> pipe_r[0].qa && pipe_r[0].shift)
    else $error("cell emitted without a window update");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FCW'(FIFO_DEPTH - PIPE_STAGES + 1))
    else $error("output queue beyond its credit limit");

endmodule

// File: tb/tb.sv
// testbench for the threshold and square dilation block
`timescale 1ns / 1ps

import trd_pkg::*;

class dilate_scoreboard;
  localparam int HALO_N = 15;
  localparam int MCOLS  = 2048;
  localparam int MROWS  = 1024;

  bit [15:0]   raw_mem [(HALO_N+1)*MCOLS];
  bit          seed_mem [2*HALO_N*MCOLS];
  int          in_r, in_c, out_r, out_c;
  bit          full;
  bit [30:0]   thr;
  bit [31:0]   scl, ofs;
  bit [10:0]   grows;
  bit [11:0]   gcols;
  res_t        pend[$];
  int          errors;

  function void clear();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0; full = 0;
  endfunction

  function void reset_state();
    thr = RST_THRESHOLD; scl = RST_SCALE; ofs = RST_OFFSET;
    grows = RST_ROWS; gcols = RST_COLS;
    clear();
  endfunction

  function int rows_n();
    int r;
    r = grows;
    if (r < 1) r = 1;
    if (r > MROWS) r = MROWS;
    return r;
  endfunction

  function int cols_n();
    int c;
    c = gcols;
    if (c < 2*HALO_N+1) c = 2*HALO_N+1;
    if (c > MCOLS) c = MCOLS;
    return c;
  endfunction

  function longint scaled(bit [15:0] raw);
    longint t;
    t = longint'($signed(raw)) * longint'($signed(scl)) + 128;
    return (t >>> 8) + longint'($signed(ofs));
  endfunction

  function void set_reg(cfg_idx_t idx, bit [31:0] v);
    case (idx)
      CFG_THRESHOLD: thr = v[30:0];
      CFG_SCALE:     scl = v;
      CFG_OFFSET:    ofs = v;
      CFG_GRID_ROWS: begin grows = v[10:0]; clear(); end
      CFG_GRID_COLS: begin gcols = v[11:0]; clear(); end
      default: ;
    endcase
  endfunction

  function void note_request(bit func, bit [15:0] smp);
    int rows, cols, x, y;
    longint v, mag, lag;
    res_t e;
    rows = rows_n();
    cols = cols_n();
    lag = HALO_N * cols + HALO_N;
    if (func == FUNC_SAMPLE && !full) begin
      v = scaled(smp);
      mag = v < 0 ? -v : v;
      raw_mem[(in_r % (HALO_N+1)) * MCOLS + in_c] = smp;
      seed_mem[(in_r % (2*HALO_N)) * MCOLS + in_c] = mag > longint'(thr);
      in_c++;
      if (in_c >= cols) begin
        in_c = 0;
        in_r++;
        if (in_r >= rows) begin
          in_r = 0;
          full = 1;
        end
      end
    end
    if (!full && longint'(in_r) * cols + in_c <= longint'(out_r) * cols + out_c + lag)
      return;
    e.row = ROW_W'(out_r);
    e.col = COL_W'(out_c);
    e.seed = seed_mem[(out_r % (2*HALO_N)) * MCOLS + out_c];
    e.region = 0;
    for (x = out_r - (HALO_N-1); x <= out_r + HALO_N; x++)
      for (y = out_c - (HALO_N-1); y <= out_c + HALO_N; y++)
        if (x >= 0 && x < rows && y >= 0 && y < cols &&
            seed_mem[(x % (2*HALO_N)) * MCOLS + y])
          e.region = 1;
    v = scaled(raw_mem[(out_r % (HALO_N+1)) * MCOLS + out_c]);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    e.value = v[31:0];
    e.last = (out_r == rows - 1) && (out_c == cols - 1);
    pend.push_back(e);
    if (e.last) begin
      clear();
    end else begin
      out_c++;
      if (out_c >= cols) begin
        out_c = 0;
        out_r++;
      end
    end
  endfunction

  function void check_result(bit [OUT_DATA_W-1:0] d, bit l);
    res_t e;
    bit bad;
    if (pend.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected cell: tdata=%h last=%b", d, l);
      return;
    end
    e = pend.pop_front();
    bad = d[9:0] != e.row || d[20:10] != e.col || d[52:21] != e.value ||
          d[53] != e.seed || d[54] != e.region || l != e.last;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display({"cell mismatch: exp row=%0d col=%0d val=%h seed=%b reg=%b last=%b,",
                  " got row=%0d col=%0d val=%h seed=%b reg=%b last=%b"},
                 e.row, e.col, e.value, e.seed, e.region, e.last,
                 d[9:0], d[20:10], d[52:21], d[53], d[54], l);
    end
  endfunction
endclass

module tb;
  localparam logic FUNC_FLUSH = ~FUNC_SAMPLE;
  localparam int   LIMIT = 200000;
  localparam int   HOLD_CYCLES = 3000;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample
  logic [IN_USER_W-1:0]  in_tuser = '0;   // func
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;       // row, col, value_q, is_seed, in_region
  logic                  out_tlast;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DW-1:0]     cfg_data = '0;

  dilate_scoreboard sb;
  bit send_gaps = 1, recv_gaps = 1, hold_req = 0;
  int idle_cycles = 0;
  int rand_items = 0;

  threshold_region_dilate_top uut (.*);

  always #5 clk = ~clk;

  task automatic send_request(bit func, bit [15:0] smp);
    int gap;
    gap = send_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= func;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    sb.note_request(func, smp);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [31:0] v);
    in_tvalid <= 0;
    while (sb.pend.size() != 0) @(posedge clk);
    repeat (15 * sb.cols_n() + 40) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, v);
  endtask

  // samples with some flush noise, then drain the frame once it is complete
  task automatic run_frame(int n, bit count_it);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) send_request(FUNC_FLUSH, $urandom());
      send_request(FUNC_SAMPLE, $urandom());
      if (count_it) rand_items++;
    end
    while (sb.full) send_request($urandom_range(0, 3) != 0 ? FUNC_FLUSH : FUNC_SAMPLE,
                                 $urandom());
  endtask

  task automatic set_grid(int rows, int cols);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
  endtask

  task automatic random_levels();
    case ($urandom_range(0, 4))
      0: write_reg(CFG_SCALE, 32'h8000_0000);
      1: write_reg(CFG_SCALE, 32'h7fff_ffff);
      default: write_reg(CFG_SCALE, $urandom());
    endcase
    write_reg(CFG_OFFSET, $urandom_range(0, 1) ? $urandom() : 32'd0);
    case ($urandom_range(0, 3))
      0: write_reg(CFG_THRESHOLD, 0);
      1: write_reg(CFG_THRESHOLD, 32'h7fff_ffff);
      default: write_reg(CFG_THRESHOLD, $urandom() & 32'h7fff_ffff);
    endcase
  endtask

  // result side: random stalls, idle-free stretches and one long hold-off
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = recv_gaps ? $urandom_range(0, 8) : 0;
      if (hold_req) begin
        out_tready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int k, s;
    sb = new;
    sb.reset_state();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: smallest grid, extreme samples, extreme levels
    write_reg(CFG_THRESHOLD, 32'd30000 << 16);
    write_reg(CFG_SCALE, 32'h0100_0000);
    write_reg(CFG_OFFSET, 0);
    set_grid(0, 0);
    send_request(FUNC_SAMPLE, 16'h7fff);
    send_request(FUNC_SAMPLE, 16'h8000);
    send_request(FUNC_FLUSH, 16'hffff);
    send_request(FUNC_SAMPLE, 16'h0000);
    send_request(FUNC_SAMPLE, 16'hffff);
    send_request(FUNC_SAMPLE, 16'h5555);
    send_request(FUNC_SAMPLE, 16'haaaa);
    run_frame(25, 0);
    for (k = 0; k < 2; k++) begin
      write_reg(CFG_SCALE, k ? 32'h8000_0000 : 32'h7fff_ffff);
      write_reg(CFG_OFFSET, k ? 32'h8000_0000 : 32'h7fff_ffff);
      write_reg(CFG_THRESHOLD, k ? 32'd0 : 32'h7fff_ffff);
      run_frame(31, 0);
    end
    write_reg(CFG_SCALE, 32'h0100_0000);
    write_reg(CFG_OFFSET, 0);

    // random frames on small grids
    while (rand_items < 250) begin
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      random_levels();
      set_grid($urandom_range(1, 18), $urandom_range(31, 34));
      if ($urandom_range(0, 4) == 0) begin
        run_frame($urandom_range(1, sb.rows_n() * sb.cols_n() - 1), 1);
      end else begin
        run_frame(sb.rows_n() * sb.cols_n(), 1);
      end
    end

    // input back-pressure from a long output hold-off
    send_gaps = 0;
    recv_gaps = 1;
    write_reg(CFG_THRESHOLD, 32'd28000 << 16);
    set_grid(2, 31);
    hold_req = 1;
    run_frame(62, 0);

    // largest sizes: short runs abandoned mid-frame
    set_grid(2047, 31);
    run_frame(40, 0);
    set_grid(1, 4095);
    recv_gaps = 0;
    run_frame(40, 0);
    set_grid(1024, 2048);
    run_frame(40, 0);
    in_tvalid <= 0;

    while (sb.pend.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pend.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
